FILE: hw/rtl/fsfp_pkg.sv
// ----------------------------------------------------------------------------
// fsfp_pkg
// Shared types, constants and the scaling function of the sample frame parser.
// ----------------------------------------------------------------------------
package fsfp_pkg;

    localparam int NUM_CHAN   = 4;
    localparam int WORD_W     = 16;
    localparam int VALUE_W    = 18;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_W      = 4;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD_W     = WORD_W + GAIN_W;
    localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
    localparam int DIFF_W     = SCALED_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] START_MARK = 8'h40;
    localparam logic [7:0] END_MARK   = 8'h21;

    localparam logic [POS_W-1:0] FIRST_WORD_POS = 4'd1;
    localparam logic [POS_W-1:0] LAST_WORD_POS  = 4'd8;
    localparam logic [POS_W-1:0] LAST_POS       = 4'd11;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET = 1'b1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4981;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd40000;

    localparam logic signed [DIFF_W-1:0] VALUE_MAX = DIFF_W'(131071);
    localparam logic signed [DIFF_W-1:0] VALUE_MIN = -DIFF_W'(131072);

    typedef logic [NUM_CHAN-1:0][WORD_W-1:0]   frame_t;
    typedef logic [NUM_CHAN-1:0][SCALED_W-1:0] scaled_t;
    typedef logic signed [VALUE_W-1:0]         value_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic value_t offset_saturate(input logic [SCALED_W-1:0] scaled,
                                               input logic [OFFSET_W-1:0] offset);
        logic signed [DIFF_W-1:0] diff;
        value_t                   result;
        diff = $signed({1'b0, scaled}) - $signed({{(DIFF_W-OFFSET_W){1'b0}}, offset});
        if (diff > VALUE_MAX)
        begin
            result = VALUE_MAX[VALUE_W-1:0];
        end
        else if (diff < VALUE_MIN)
        begin
            result = VALUE_MIN[VALUE_W-1:0];
        end
        else
        begin
            result = diff[VALUE_W-1:0];
        end
        return result;
    endfunction

endpackage

FILE: hw/rtl/fsfp_front.sv
// ----------------------------------------------------------------------------
// fsfp_front
// Byte parser: tracks the frame position, collects the four words and pushes
// a finished frame into the queue when the closing mark arrives.
// ----------------------------------------------------------------------------
module fsfp_front
    import fsfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    rx_byte,
    input  queue_status_t q_status,
    output logic          push,
    output frame_t        push_frame
);

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       hold_reg;
    logic [7:0]       hold_next;
    frame_t           words_reg;
    logic             word_we;
    logic [1:0]       word_idx;
    logic             accept;

    assign in_ready   = !q_status.full;
    assign accept     = in_valid && in_ready;
    assign word_idx   = 2'(pos_reg[POS_W-1:1] - 3'd1);
    assign push_frame = words_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        hold_next     = hold_reg;
        word_we       = 1'b0;
        push          = 1'b0;
        if (accept)
        begin
            if (rx_byte == START_MARK)
            begin
                in_frame_next = 1'b1;
                pos_next      = FIRST_WORD_POS;
                hold_next     = 8'd0;
            end
            else if ((rx_byte == END_MARK && pos_reg != LAST_POS) || pos_reg > LAST_POS)
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                hold_next     = 8'd0;
            end
            else if (in_frame_reg && pos_reg == LAST_POS)
            begin
                push          = (rx_byte == END_MARK);
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                if (in_frame_reg && pos_reg >= FIRST_WORD_POS && pos_reg <= LAST_WORD_POS)
                begin
                    if (pos_reg[0])
                    begin
                        hold_next = rx_byte;
                    end
                    else
                    begin
                        word_we = 1'b1;
                    end
                end
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            hold_reg     <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            hold_reg     <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            words_reg[word_idx] <= {rx_byte, hold_reg};
        end
    end

endmodule

FILE: hw/rtl/fsfp_queue.sv
// ----------------------------------------------------------------------------
// fsfp_queue
// Two-entry frame queue between the parser and the scaling pipeline.
// ----------------------------------------------------------------------------
module fsfp_queue
    import fsfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_t        push_frame,
    input  logic          pop,
    output frame_t        pop_frame,
    output queue_status_t q_status
);

    frame_t     mem [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_status.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == 2'd0);
    assign pop_frame      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

FILE: hw/rtl/fsfp_back.sv
// ----------------------------------------------------------------------------
// fsfp_back
// Scaling pipeline: multiplies each word by the gain, then subtracts the
// offset, saturates, and holds the result in the output register.
// ----------------------------------------------------------------------------
module fsfp_back
    import fsfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  queue_status_t       q_status,
    input  frame_t              pop_frame,
    output logic                pop,
    input  logic [GAIN_W-1:0]   scale_gain,
    input  logic [OFFSET_W-1:0] scale_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output value_t              chan0_value,
    output value_t              chan1_value,
    output value_t              chan2_value,
    output value_t              chan3_value
);

    logic    mul_valid_reg;
    scaled_t scaled_reg;
    logic    out_valid_reg;
    value_t  value_reg [NUM_CHAN];
    logic    out_adv;
    logic    mul_adv;

    assign out_adv = !out_valid_reg || out_ready;
    assign mul_adv = !mul_valid_reg || out_adv;
    assign pop     = !q_status.empty && mul_adv;

    assign out_valid   = out_valid_reg;
    assign chan0_value = value_reg[0];
    assign chan1_value = value_reg[1];
    assign chan2_value = value_reg[2];
    assign chan3_value = value_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_adv)
            begin
                mul_valid_reg <= pop;
            end
            if (out_adv)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (pop)
            begin
                prod          = PROD_W'(pop_frame[i]) * PROD_W'(scale_gain);
                scaled_reg[i] <= prod[PROD_W-1:FRAC_SHIFT];
            end
            if (out_adv && mul_valid_reg)
            begin
                value_reg[i] <= offset_saturate(scaled_reg[i], scale_offset);
            end
        end
    end

endmodule

FILE: hw/rtl/four_channel_sample_frame_parser_top.sv
// ----------------------------------------------------------------------------
// four_channel_sample_frame_parser_top
// Parses twelve-byte sample frames and emits the four scaled channel values.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the frame queue has room; a frame
// result follows each closing mark that ends a full frame. The result passes
// through the frame queue, the multiply register and the output register.
// A two-entry frame queue lets the parser run while the output is stalled.
// Reset: asynchronous, active low; parser idle, queue empty, gain 4981,
// offset 40000. No clearing pass is needed.
module four_channel_sample_frame_parser_top
    import fsfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output value_t                chan0_value,
    output value_t                chan1_value,
    output value_t                chan2_value,
    output value_t                chan3_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;
    queue_status_t       q_status;
    logic                push;
    frame_t              push_frame;
    logic                pop;
    frame_t              pop_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_SCALE_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    fsfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    fsfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .q_status   (q_status)
    );

    fsfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_frame    (pop_frame),
        .pop          (pop),
        .scale_gain   (gain_reg),
        .scale_offset (offset_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chan0_value  (chan0_value),
        .chan1_value  (chan1_value),
        .chan2_value  (chan2_value),
        .chan3_value  (chan3_value)
    );

endmodule
